>>> sv/lsd_pkg.sv
`timescale 1ns / 1ps

package lsd_pkg;

    // field widths
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 32;
    localparam int KEY_W      = 64;
    localparam int IN_TDATA_W = BYTE_W + 3 * WORD_W;
    localparam int OUT_TDATA_W = BYTE_W;

    // tdata field offsets on the slave side
    localparam int HDR_A_LSB = BYTE_W;
    localparam int HDR_B_LSB = HDR_A_LSB + WORD_W;
    localparam int HDR_C_LSB = HDR_B_LSB + WORD_W;

    // first plain byte of a good frame
    localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'h4B;

    // feedback taps
    localparam int TAP_LOW  = 1;
    localparam int TAP_NEXT = 2;
    localparam int TAP_MID  = 11;
    localparam int TAP_TOP  = 31;

    // result of one keystream step for one byte
    typedef struct packed {
        logic [BYTE_W-1:0] plain_byte;
        logic              frame_bad;
    } lsd_result_t;

    // eight shift steps, new bit in at bit 0
    function automatic logic [WORD_W-1:0] lfsr_advance_byte(input logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] v;
        logic              nb;
        v = s;
        for (int k = 0; k < BYTE_W; k++)
        begin
            nb = v[TAP_LOW] ^ v[TAP_NEXT] ^ v[TAP_MID] ^ v[TAP_TOP];
            v  = {v[WORD_W-2:0], nb};
        end
        return v;
    endfunction

endpackage

>>> sv/lsd_keystream.sv
`timescale 1ns / 1ps

module lsd_keystream (
    input  logic [lsd_pkg::WORD_W-1:0] lfsr_cur,
    input  logic [lsd_pkg::KEY_W-1:0]  cipher_key,
    input  logic [lsd_pkg::WORD_W-1:0] header_word_a,
    input  logic [lsd_pkg::WORD_W-1:0] header_word_b,
    input  logic [lsd_pkg::WORD_W-1:0] header_word_c,
    input  logic                       first_of_frame,
    input  logic [lsd_pkg::BYTE_W-1:0] cipher_byte,
    input  logic                       bad_cur,
    output logic [lsd_pkg::WORD_W-1:0] lfsr_next,
    output lsd_pkg::lsd_result_t       result
);
    import lsd_pkg::*;

    logic [WORD_W-1:0] seed;
    logic [WORD_W-1:0] start;
    logic [BYTE_W-1:0] plain;

    // seed from both key halves and the three header words
    assign seed = cipher_key[KEY_W-1:WORD_W] ^ cipher_key[WORD_W-1:0]
                ^ header_word_a ^ header_word_b ^ header_word_c;

    // reseed on the first byte, otherwise carry on
    assign start = first_of_frame ? seed : lfsr_cur;

    assign lfsr_next = lfsr_advance_byte(start);
    assign plain     = cipher_byte ^ lfsr_next[BYTE_W-1:0];

    // marker check on the first byte only, sticky otherwise
    always_comb
    begin
        result.plain_byte = plain;
        if (first_of_frame)
        begin
            result.frame_bad = (plain != MARKER_BYTE);
        end
        else
        begin
            result.frame_bad = bad_cur;
        end
    end

endmodule

>>> sv/lfsr_stream_decrypt_unit.sv
`timescale 1ns / 1ps

// Stream decryptor for radio frame payloads, one byte per request.
// Configuration: cfg_wr_en / cfg_wr_data load the 64-bit key; write it only
// while no request is in flight.
// Slave channel: tdata carries the cipher byte and three header words, tuser
// marks the first byte of a frame (reseeds the keystream from key and header
// words), tlast marks the last byte and is passed through unchanged.
// Master channel: tdata is the plain byte, tuser the sticky bad-frame flag
// (set when the first plain byte of the frame is not the marker byte),
// tlast the copy of the input tlast.
// Master tvalid rises once the request has passed the input register and then
// the result register, where the result can be taken. Throughput: one byte
// per cycle while the receiver does not stall; the eight keystream steps are
// flattened XOR logic between the two registers.
// Reset clears the key, the keystream state, the bad flag and both valid bits.
// When the receiver stalls, the result register holds and the input register
// takes one more request; after that s_axis_tready drops until the master side
// moves again. No request is dropped or repeated.
module lfsr_stream_decrypt_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [lsd_pkg::KEY_W-1:0]       cfg_wr_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // cipher_byte, header_word_a, header_word_b, header_word_c
    input  logic [lsd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // first_of_frame
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // plain_byte
    output logic [lsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // frame_bad
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);
    import lsd_pkg::*;

    logic [KEY_W-1:0]      key_reg;
    logic                  in_valid_reg;
    logic [IN_TDATA_W-1:0] in_data_reg;
    logic                  in_first_reg;
    logic                  in_last_reg;
    logic [WORD_W-1:0]     lfsr_reg;
    logic [WORD_W-1:0]     lfsr_next;
    logic                  bad_reg;
    logic                  out_valid_reg;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic                  out_bad_reg;
    logic                  out_last_reg;
    lsd_result_t           ks_result;
    logic                  advance;
    logic                  in_take;

    // move from input register to result register
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // key register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            key_reg <= cfg_wr_data;
        end
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg  <= s_axis_tdata;
            in_first_reg <= s_axis_tuser;
            in_last_reg  <= s_axis_tlast;
        end
    end

    // keystream and marker check
    lsd_keystream u_keystream (
        .lfsr_cur       (lfsr_reg),
        .cipher_key     (key_reg),
        .header_word_a  (in_data_reg[HDR_A_LSB +: WORD_W]),
        .header_word_b  (in_data_reg[HDR_B_LSB +: WORD_W]),
        .header_word_c  (in_data_reg[HDR_C_LSB +: WORD_W]),
        .first_of_frame (in_first_reg),
        .cipher_byte    (in_data_reg[BYTE_W-1:0]),
        .bad_cur        (bad_reg),
        .lfsr_next      (lfsr_next),
        .result         (ks_result)
    );

    // keystream state and sticky flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= '0;
            bad_reg  <= 1'b0;
        end
        else if (advance)
        begin
            lfsr_reg <= lfsr_next;
            bad_reg  <= ks_result.frame_bad;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= ks_result.plain_byte;
            out_bad_reg  <= ks_result.frame_bad;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_bad_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // a first byte sets the flag from the marker compare
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_first_reg |=> out_bad_reg == (out_byte_reg != MARKER_BYTE))
        else $error("bad flag does not follow marker check");

    // other bytes keep the sticky flag
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_first_reg |=> bad_reg == $past(bad_reg))
        else $error("bad flag changed outside a first byte");

    // an all-zero keystream stays zero without a reseed
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_first_reg && lfsr_reg == '0 |=> lfsr_reg == '0)
        else $error("zero keystream left zero without reseed");

    // the flag given out matches the state after each step
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_bad_reg == bad_reg)
        else $error("output flag differs from state");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lsd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int STEADY_ITEMS = 200;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_REPORTS  = 10;

    // one decrypted byte as it should leave the block
    typedef struct packed {
        logic [BYTE_W-1:0] plain_byte;
        logic              frame_bad;
        logic              last_out;
    } plain_rec_t;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   cfg_wr_en     = 1'b0;
    logic [KEY_W-1:0]       cfg_wr_data   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // cipher_byte, header_word_a, header_word_b, header_word_c
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // first_of_frame
    logic                   s_axis_tuser  = 1'b0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // plain_byte
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // frame_bad
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;

    // keystream model
    logic [KEY_W-1:0]  key_model  = '0;
    logic [WORD_W-1:0] ks_state   = '0;
    logic              bad_sticky = 1'b0;

    plain_rec_t pending_plain[$];
    int         mismatch_count = 0;
    int         sent_count     = 0;
    int         cycle_count    = 0;
    bit         tx_idle_en     = 1'b1;
    bit         rx_stall_en    = 1'b1;

    lfsr_stream_decrypt_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_plain.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // eight register shifts per byte, feedback into bit 0
    function automatic logic [WORD_W-1:0] advance_keystream(input logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] r;
        r = s;
        repeat (BYTE_W)
            r = {r[WORD_W-2:0], r[TAP_LOW] ^ r[TAP_NEXT] ^ r[TAP_MID] ^ r[TAP_TOP]};
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] frame_seed(input logic [WORD_W-1:0] ha, hb, hc);
        return key_model[KEY_W-1:WORD_W] ^ key_model[WORD_W-1:0] ^ ha ^ hb ^ hc;
    endfunction

    // work out the plain byte and flag for one accepted request
    function automatic void predict_plain(input logic [BYTE_W-1:0] cb, input logic first,
                                          input logic last, input logic [WORD_W-1:0] ha,
                                          input logic [WORD_W-1:0] hb,
                                          input logic [WORD_W-1:0] hc);
        plain_rec_t rec;
        if (first)
            ks_state = frame_seed(ha, hb, hc);
        ks_state = advance_keystream(ks_state);
        rec.plain_byte = cb ^ ks_state[BYTE_W-1:0];
        if (first)
            bad_sticky = (rec.plain_byte != MARKER_BYTE);
        rec.frame_bad = bad_sticky;
        rec.last_out  = last;
        pending_plain.push_back(rec);
    endfunction

    // receiver with random back-pressure
    always @(negedge clk)
        m_axis_tready <= !rx_stall_en || ($urandom_range(99) >= 7);

    // result checker
    always @(posedge clk)
    begin
        plain_rec_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_plain.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result plain=%02h bad=%b last=%b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                want = pending_plain.pop_front();
                if (m_axis_tdata !== want.plain_byte || m_axis_tuser !== want.frame_bad ||
                    m_axis_tlast !== want.last_out)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: expected plain=%02h bad=%b last=%b,",
                                 want.plain_byte, want.frame_bad, want.last_out,
                                 " got plain=%02h bad=%b last=%b",
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    // offer one request and wait for it to be taken
    task automatic send_byte(input logic [BYTE_W-1:0] cb, input logic first,
                             input logic last, input logic [WORD_W-1:0] ha,
                             input logic [WORD_W-1:0] hb, input logic [WORD_W-1:0] hc);
        @(negedge clk);
        while (tx_idle_en && $urandom_range(99) < 7)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hc, hb, ha, cb};
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_plain(cb, first, last, ha, hb, hc);
        sent_count++;
    endtask

    // frame whose first byte decrypts to the marker, or to something else
    task automatic send_frame(input int len, input bit good, input bit closed,
                              input logic [WORD_W-1:0] ha, input logic [WORD_W-1:0] hb,
                              input logic [WORD_W-1:0] hc);
        logic [BYTE_W-1:0] cb;
        logic [WORD_W-1:0] ks;
        ks = advance_keystream(frame_seed(ha, hb, hc));
        cb = MARKER_BYTE ^ ks[BYTE_W-1:0];
        if (!good)
            cb ^= BYTE_W'($urandom_range(1, 255));
        send_byte(cb, 1'b1, closed && len == 1, ha, hb, hc);
        for (int i = 1; i < len; i++)
            send_byte(BYTE_W'($urandom), 1'b0, closed && i == len - 1,
                      $urandom, $urandom, $urandom);
    endtask

    // stop sending and wait for every result to come back
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_plain.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_key(input logic [KEY_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        key_model = value;
    endtask

    // bytes before any frame start: zero keystream, plain equals cipher
    task automatic test_pre_frame_bytes();
        send_byte(8'h00, 1'b0, 1'b0, '0, '0, '0);
        send_byte(8'hFF, 1'b0, 1'b1, '1, '1, '1);
        send_byte(8'h5A, 1'b0, 1'b0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0F0F_0F0F);
    endtask

    // reset key and zero headers give an all-zero seed
    task automatic test_zero_seed_frame();
        send_frame(3, 1'b1, 1'b1, '0, '0, '0);
    endtask

    task automatic test_header_extremes();
        write_key(64'h0123_4567_89AB_CDEF);
        send_frame(2, 1'b1, 1'b1, '1, '1, '1);
        send_frame(1, 1'b1, 1'b1, '1, '0, 32'hAAAA_5555);
        send_frame(2, 1'b0, 1'b1, '0, 32'h8000_0001, '1);
    endtask

    // bad marker sets the flag for the rest of the frame, a good one clears it
    task automatic test_sticky_flag();
        send_frame(4, 1'b0, 1'b1, $urandom, $urandom, $urandom);
        send_frame(2, 1'b1, 1'b1, $urandom, $urandom, $urandom);
    endtask

    // keystream and flag carry on past a last byte
    task automatic test_stream_after_last();
        send_frame(2, 1'b0, 1'b1, $urandom, $urandom, $urandom);
        send_byte(8'h00, 1'b0, 1'b0, $urandom, $urandom, $urandom);
        send_byte(8'hFF, 1'b0, 1'b1, $urandom, $urandom, $urandom);
    endtask

    // key halves that cancel and key halves that invert the headers
    task automatic test_key_extremes();
        write_key('1);
        send_frame(2, 1'b1, 1'b1, '0, '0, '0);
        write_key(64'hFFFF_FFFF_0000_0000);
        send_frame(2, 1'b1, 1'b1, $urandom, $urandom, $urandom);
    endtask

    // mostly well-formed frames, some broken frames and loose bytes
    task automatic test_random_traffic();
        int   goal;
        int   next_rekey;
        int   kind;
        int   len;
        logic [WORD_W-1:0] w;
        goal       = sent_count + RANDOM_ITEMS;
        next_rekey = sent_count + 350;
        while (sent_count < goal)
        begin
            if (sent_count >= next_rekey)
            begin
                next_rekey = sent_count + 350;
                w = $urandom;
                case ($urandom_range(4))
                    0: write_key('0);
                    1: write_key('1);
                    2: write_key({w, w});
                    default: write_key({w, WORD_W'($urandom)});
                endcase
            end
            kind = $urandom_range(99);
            len  = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            if (kind < 80)
                send_frame(len, $urandom_range(4) != 0, 1'b1, $urandom, $urandom, $urandom);
            else if (kind < 90)
                send_frame(len, $urandom_range(1) == 1, 1'b0, $urandom, $urandom, $urandom);
            else
                repeat (len)
                    send_byte(BYTE_W'($urandom), $urandom_range(7) == 0,
                              $urandom_range(3) == 0, $urandom, $urandom, $urandom);
        end
    endtask

    // back-to-back traffic with neither side holding off
    task automatic test_steady_stream();
        int goal;
        write_key({32'($urandom), 32'($urandom)});
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        goal = sent_count + STEADY_ITEMS;
        while (sent_count < goal)
            send_frame($urandom_range(1, 16), $urandom_range(3) != 0, 1'b1,
                       $urandom, $urandom, $urandom);
        drain_results();
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    // test sequence
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_pre_frame_bytes();
        test_zero_seed_frame();
        test_header_extremes();
        test_sticky_flag();
        test_stream_after_last();
        test_key_extremes();
        test_random_traffic();
        test_steady_stream();

        drain_results();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
